[rtl/core/distinct_value_frequency_count_top_defines.svh]
// Assertion macros for the distinct value frequency counter.
// Included by the top level; depends on nothing else.
`ifndef DISTINCT_VALUE_FREQUENCY_COUNT_TOP_DEFINES_SVH
`define DISTINCT_VALUE_FREQUENCY_COUNT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DVFC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dvfc assertion failed");
`define DVFC_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("dvfc assertion failed");
`else
`define DVFC_ASSERT(label, clk, rst_n, prop)
`define DVFC_ASSERT_NORST(label, clk, prop)
`endif

`endif

[rtl/core/dvfc_pkg.sv]
// Package for the distinct value frequency counter: sizes, types, FSM states.
// Used by the interfaces, table, sequencer and top level; depends on nothing.
package dvfc_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 32;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [USED_W-1:0]         used_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;

  localparam count_t COUNT_MAX = '1;
  localparam count_t COUNT_ONE = count_t'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_INSERT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   wr_en;
    idx_t   wr_addr;
    value_t wr_value;
    count_t wr_count;
  } mem_req_t;

  typedef struct packed {
    value_t value;
    count_t count;
  } mem_rsp_t;

  typedef struct packed {
    logic  loading;
    used_t used;
  } status_t;

endpackage

[rtl/core/dvfc_if.sv]
// Valid/ready channel interfaces for sample input and pair output.
// Depends on dvfc_pkg for the payload types.
interface dvfc_in_if;
  logic            valid;
  logic            ready;
  dvfc_pkg::value_t sample_value;
  logic            end_of_run;

  modport source (output valid, output sample_value, output end_of_run, input ready);
  modport sink   (input valid, input sample_value, input end_of_run, output ready);
endinterface

interface dvfc_out_if;
  logic             valid;
  logic             ready;
  dvfc_pkg::value_t distinct_value;
  dvfc_pkg::count_t occurrences;
  logic             final_pair;
  logic             table_overflowed;

  modport source (output valid, output distinct_value, output occurrences,
                  output final_pair, output table_overflowed, input ready);
  modport sink   (input valid, input distinct_value, input occurrences,
                  input final_pair, input table_overflowed, output ready);
endinterface

[rtl/core/dvfc_table.sv]
// Value and count memories of the distinct value table, with registered read data.
// Depends on dvfc_pkg for the request and response structs.
module dvfc_table (
  input  logic               clk,
  input  dvfc_pkg::mem_req_t req,
  output dvfc_pkg::mem_rsp_t rsp
);

  dvfc_pkg::value_t value_mem [dvfc_pkg::TABLE_DEPTH];
  dvfc_pkg::count_t count_mem [dvfc_pkg::TABLE_DEPTH];
  dvfc_pkg::mem_rsp_t rsp_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      value_mem[req.wr_addr] <= req.wr_value;
      count_mem[req.wr_addr] <= req.wr_count;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rsp_r.value <= value_mem[req.rd_addr];
      rsp_r.count <= count_mem[req.rd_addr];
    end
  end

  assign rsp = rsp_r;

endmodule

[rtl/core/dvfc_ctrl.sv]
// Sequencer: searches the table, counts or appends, then streams out the pairs.
// Depends on dvfc_pkg and the channel interfaces in dvfc_if.
module dvfc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  dvfc_in_if.sink            in_ch,
  dvfc_out_if.source         out_ch,
  output dvfc_pkg::mem_req_t req,
  input  dvfc_pkg::mem_rsp_t rsp,
  output dvfc_pkg::status_t  status
);

  dvfc_pkg::state_t state_r, state_nxt;
  dvfc_pkg::idx_t   idx_r, idx_nxt;
  dvfc_pkg::used_t  used_r, used_nxt;
  logic             ovf_r, ovf_nxt;
  dvfc_pkg::value_t sample_r, sample_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  dvfc_pkg::value_t out_value_r, out_value_nxt;
  dvfc_pkg::count_t out_count_r, out_count_nxt;
  logic             out_final_r, out_final_nxt;
  logic             out_ovf_r, out_ovf_nxt;
  dvfc_pkg::used_t  idx_plus1;
  dvfc_pkg::state_t done_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dvfc_pkg::ST_IDLE;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    sample_r    <= sample_nxt;
    last_r      <= last_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign idx_plus1  = dvfc_pkg::used_t'(idx_r) + dvfc_pkg::used_t'(1);
  assign done_state = last_r ? dvfc_pkg::ST_EMIT_RD : dvfc_pkg::ST_IDLE;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    ovf_nxt       = ovf_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;
    req           = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      dvfc_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          sample_nxt  = in_ch.sample_value;
          last_nxt    = in_ch.end_of_run;
          idx_nxt     = '0;
          req.rd_en   = 1'b1;
          req.rd_addr = '0;
          state_nxt   = (used_r == '0) ? dvfc_pkg::ST_INSERT : dvfc_pkg::ST_LOOKUP;
        end
      end
      dvfc_pkg::ST_LOOKUP: begin
        if (rsp.value == sample_r) begin
          req.wr_en    = 1'b1;
          req.wr_addr  = idx_r;
          req.wr_value = sample_r;
          req.wr_count = (rsp.count == dvfc_pkg::COUNT_MAX) ? rsp.count
                                                            : rsp.count + dvfc_pkg::COUNT_ONE;
          idx_nxt      = '0;
          state_nxt    = done_state;
        end else if (idx_plus1 == used_r) begin
          state_nxt = dvfc_pkg::ST_INSERT;
        end else begin
          idx_nxt     = idx_plus1[dvfc_pkg::IDX_W-1:0];
          req.rd_en   = 1'b1;
          req.rd_addr = idx_plus1[dvfc_pkg::IDX_W-1:0];
        end
      end
      dvfc_pkg::ST_INSERT: begin
        if (used_r < dvfc_pkg::used_t'(dvfc_pkg::TABLE_DEPTH)) begin
          req.wr_en    = 1'b1;
          req.wr_addr  = used_r[dvfc_pkg::IDX_W-1:0];
          req.wr_value = sample_r;
          req.wr_count = dvfc_pkg::COUNT_ONE;
          used_nxt     = used_r + dvfc_pkg::used_t'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        idx_nxt   = '0;
        state_nxt = done_state;
      end
      dvfc_pkg::ST_EMIT_RD: begin
        if (!out_valid_r || out_ch.ready) begin
          req.rd_en   = 1'b1;
          req.rd_addr = idx_r;
          state_nxt   = dvfc_pkg::ST_EMIT_LD;
        end
      end
      dvfc_pkg::ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rsp.value;
        out_count_nxt = rsp.count;
        out_final_nxt = (idx_plus1 == used_r);
        out_ovf_nxt   = ovf_r;
        if (idx_plus1 == used_r) begin
          used_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = dvfc_pkg::ST_IDLE;
        end else begin
          idx_nxt   = idx_plus1[dvfc_pkg::IDX_W-1:0];
          state_nxt = dvfc_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = dvfc_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready             = (state_r == dvfc_pkg::ST_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.distinct_value   = out_value_r;
  assign out_ch.occurrences      = out_count_r;
  assign out_ch.final_pair       = out_final_r;
  assign out_ch.table_overflowed = out_ovf_r;

  assign status.loading = (state_r == dvfc_pkg::ST_EMIT_LD);
  assign status.used    = used_r;

endmodule

[rtl/core/distinct_value_frequency_count_top.sv]
// Top level of the distinct value frequency counter: sequencer plus table memories.
// Depends on dvfc_pkg, dvfc_if, dvfc_table, dvfc_ctrl and the assertion macro header.
//
//   channel  direction  transaction
//   in_ch    input      one sample_value with its end_of_run mark
//   out_ch   output     one (distinct_value, occurrences) pair with final and overflow flags
//
// During lookup the single read port of the table is swept one entry per cycle over the N
// distinct values stored so far; a new sample is taken only once the last one is done.
// On the end of a run each stored pair streams out as a read of the table and then a load
// of the output register; the read waits while the sink holds ready low.
// Reset clears the state, the fill count, the overflow flag and the output valid; the memories need no clearing.
// A finished pair waits in the output register while the next sample is taken.
`include "distinct_value_frequency_count_top_defines.svh"

module distinct_value_frequency_count_top (
  input  logic       clk,
  input  logic       rst_n,
  dvfc_in_if.sink    in_ch,
  dvfc_out_if.source out_ch
);

  dvfc_pkg::mem_req_t req;
  dvfc_pkg::mem_rsp_t rsp;
  dvfc_pkg::status_t  status;

  dvfc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .req    (req),
    .rsp    (rsp),
    .status (status)
  );

  dvfc_table u_table (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  `DVFC_ASSERT(a_used_bound, clk, rst_n, status.used <= dvfc_pkg::used_t'(dvfc_pkg::TABLE_DEPTH))
  `DVFC_ASSERT(a_used_step, clk, rst_n, (status.used != $past(status.used)) |-> ((status.used == '0) || (status.used == $past(status.used) + dvfc_pkg::used_t'(1))))
  `DVFC_ASSERT(a_out_from_load, clk, rst_n, $rose(out_ch.valid) |-> $past(status.loading))

endmodule
